// File: rtl/core/tpac_pkg.sv
// shared types and constants for the triac phase-angle controller
// no dependencies; used by every file in rtl/core
package tpac_pkg;

  // operation codes of the input stream
  localparam logic [2:0] OP_SET_POWER  = 3'd0;
  localparam logic [2:0] OP_ADJUST     = 3'd1;
  localparam logic [2:0] OP_ZERO_CROSS = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_START      = 3'd4;
  localparam logic [2:0] OP_STOP       = 3'd5;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUAL_MODE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAINS_TIMEOUT = 1'b1;

  // reset values and the no-fire delay
  localparam logic [15:0] NO_FIRE           = 16'hFFFF;
  localparam logic [15:0] MAINS_TIMEOUT_RST = 16'hFFF0;
  localparam logic        DUAL_MODE_RST     = 1'b1;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;

  // one input item
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [10:0] amount;
  } item_t;

  // one result item
  typedef struct packed {
    logic        fire_first;
    logic        fire_second;
    logic        mains_lost;
    logic        running;
    logic [9:0]  power_level;
    logic [15:0] delay_first;
    logic [15:0] delay_second;
  } result_t;

endpackage

// File: rtl/core/tpac_power_map.sv
// power level to firing delay mapping for both heaters
// depends on tpac_pkg
module tpac_power_map #(
  parameter int unsigned FULL_POWER       = 1000,
  parameter int unsigned HALF_CYCLE_TICKS = 40000
) (
  input  logic [$clog2(FULL_POWER+1)-1:0] level,
  input  logic                            dual,
  output logic [15:0]                     delay_one,
  output logic [15:0]                     delay_two
);

  localparam int unsigned PW    = $clog2(FULL_POWER + 1);
  localparam int unsigned SW    = PW + 1;
  localparam int unsigned HALF  = FULL_POWER / 2;
  localparam int unsigned RATIO = HALF_CYCLE_TICKS / FULL_POWER;
  localparam int unsigned RW    = $clog2(RATIO + 1);
  localparam int unsigned DW    = (SW + RW > 16) ? SW + RW : 16;

  // share to delay: capped share, low shares never fire
  function automatic logic [15:0] share_delay(input logic [SW-1:0] s);
    logic [SW-1:0] sc;
    logic [DW-1:0] prod;
    sc   = (s > SW'(FULL_POWER)) ? SW'(FULL_POWER) : s;
    prod = DW'(SW'(FULL_POWER) - sc) * DW'(RATIO);
    if (sc <= SW'(1)) begin
      share_delay = tpac_pkg::NO_FIRE;
    end else begin
      share_delay = prod[15:0];
    end
  endfunction

  logic [SW-1:0] share_one;
  logic [SW-1:0] share_two;

  // split the range: first heater takes the lower half, second the upper
  always_comb begin
    share_one = (level > PW'(HALF)) ? SW'(FULL_POWER) : {level, 1'b0};
    share_two = (level >= PW'(HALF)) ? {level - PW'(HALF), 1'b0} : '0;
  end

  assign delay_one = share_delay(dual ? share_one : {1'b0, level});
  assign delay_two = dual ? share_delay(share_two) : tpac_pkg::NO_FIRE;

endmodule

// File: rtl/core/tpac_state.sv
// controller state and per-item update: power, delays, tick counter, fault
// depends on tpac_pkg and tpac_power_map
module tpac_state #(
  parameter int unsigned FULL_POWER       = 1000,
  parameter int unsigned HALF_CYCLE_TICKS = 40000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tpac_pkg::item_t   item,
  input  logic              dual,
  input  logic [15:0]       timeout,
  output tpac_pkg::result_t res
);

  localparam int unsigned PW = $clog2(FULL_POWER + 1);
  localparam int unsigned LW = PW + 12;

  logic [PW-1:0] power_now, power_now_next;
  logic [15:0]   pend_one, pend_one_next;
  logic [15:0]   pend_two, pend_two_next;
  logic [15:0]   act_one, act_one_next;
  logic [15:0]   act_two, act_two_next;
  logic [15:0]   tick_count, tick_count_next;
  logic          enabled, enabled_next;
  logic          fault, fault_next;

  logic signed [LW-1:0] amt_ext;
  logic signed [LW-1:0] lvl_raw;
  logic [PW-1:0]        lvl;
  logic [15:0]          map_one;
  logic [15:0]          map_two;
  logic [15:0]          tick_inc;
  logic                 fire_one;
  logic                 fire_two;

  // new level for set or adjust, clamped to 0..full
  always_comb begin
    amt_ext = LW'(item.amount);
    if (item.operation == tpac_pkg::OP_ADJUST) begin
      lvl_raw = $signed({12'b0, power_now}) + amt_ext;
    end else begin
      lvl_raw = amt_ext;
    end
    if (lvl_raw < 0) begin
      lvl = '0;
    end else if (lvl_raw > $signed(LW'(FULL_POWER))) begin
      lvl = PW'(FULL_POWER);
    end else begin
      lvl = lvl_raw[PW-1:0];
    end
  end

  tpac_power_map #(
    .FULL_POWER       (FULL_POWER),
    .HALF_CYCLE_TICKS (HALF_CYCLE_TICKS)
  ) u_map (
    .level     (lvl),
    .dual      (dual),
    .delay_one (map_one),
    .delay_two (map_two)
  );

  // saturating tick advance
  assign tick_inc = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;

  // operation decode
  always_comb begin
    power_now_next  = power_now;
    pend_one_next   = pend_one;
    pend_two_next   = pend_two;
    act_one_next    = act_one;
    act_two_next    = act_two;
    tick_count_next = tick_count;
    enabled_next    = enabled;
    fault_next      = fault;
    fire_one        = 1'b0;
    fire_two        = 1'b0;
    case (item.operation)
      tpac_pkg::OP_SET_POWER, tpac_pkg::OP_ADJUST: begin
        power_now_next = lvl;
        pend_one_next  = map_one;
        pend_two_next  = map_two;
      end
      tpac_pkg::OP_ZERO_CROSS: begin
        if (enabled && !fault) begin
          tick_count_next = '0;
          act_one_next    = pend_one;
          act_two_next    = pend_two;
        end
      end
      tpac_pkg::OP_TICK: begin
        if (enabled && !fault) begin
          fire_one        = (act_one != tpac_pkg::NO_FIRE) && (tick_count == act_one);
          fire_two        = (act_two != tpac_pkg::NO_FIRE) && (tick_count == act_two);
          tick_count_next = tick_inc;
          if (tick_inc >= timeout) begin
            fault_next   = 1'b1;
            enabled_next = 1'b0;
          end
        end
      end
      tpac_pkg::OP_START: begin
        if (!fault) begin
          enabled_next = 1'b1;
        end
      end
      tpac_pkg::OP_STOP: begin
        power_now_next = '0;
        pend_one_next  = tpac_pkg::NO_FIRE;
        pend_two_next  = tpac_pkg::NO_FIRE;
        enabled_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // state registers, updated once per executed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      power_now  <= '0;
      pend_one   <= tpac_pkg::NO_FIRE;
      pend_two   <= tpac_pkg::NO_FIRE;
      act_one    <= tpac_pkg::NO_FIRE;
      act_two    <= tpac_pkg::NO_FIRE;
      tick_count <= '0;
      enabled    <= 1'b0;
      fault      <= 1'b0;
    end else if (step) begin
      power_now  <= power_now_next;
      pend_one   <= pend_one_next;
      pend_two   <= pend_two_next;
      act_one    <= act_one_next;
      act_two    <= act_two_next;
      tick_count <= tick_count_next;
      enabled    <= enabled_next;
      fault      <= fault_next;
    end
  end

  // result reports the state after the item
  always_comb begin
    res.fire_first   = fire_one;
    res.fire_second  = fire_two;
    res.mains_lost   = fault_next;
    res.running      = enabled_next;
    res.power_level  = 10'(power_now_next);
    res.delay_first  = pend_one_next;
    res.delay_second = pend_two_next;
  end

  // firing enable and fault are exclusive
  a_run_fault_excl: assert property (@(posedge clk) disable iff (rst)
    !(enabled && fault))
    else $error("running while mains-lost fault is set");

  // fault only clears through reset
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    fault |=> fault)
    else $error("mains-lost fault cleared without reset");

  // stop leaves no pending firing and stops
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (step && item.operation == tpac_pkg::OP_STOP) |=>
      (pend_one == tpac_pkg::NO_FIRE && pend_two == tpac_pkg::NO_FIRE && !enabled
       && power_now == '0))
    else $error("stop left firing pending");

  // single mode never schedules the second heater
  a_single_no_second: assert property (@(posedge clk) disable iff (rst)
    (step && !dual && (item.operation == tpac_pkg::OP_SET_POWER
                       || item.operation == tpac_pkg::OP_ADJUST)) |=>
      (pend_two == tpac_pkg::NO_FIRE))
    else $error("second heater scheduled in single mode");

endmodule

// File: rtl/core/triac_phase_angle_controller_unit.sv
// Phase-angle firing controller for two triac heaters. Every stream transaction
// (set power, adjust power, zero cross, tick, start, stop) yields exactly one
// result transaction carrying the fire pulses of that item and the controller
// status after it. One item is taken every clock cycle while m_tready does not
// hold a waiting result; an item passes through the input register and its
// result is then held in the result register, which drives m_tdata. The rate is
// set by the single pass through the level clamp and the constant-ratio delay
// multiply between the two registers. Configuration writes are applied at once
// and are meant for idle periods only.
// depends on tpac_pkg, tpac_state and tpac_power_map
module triac_phase_angle_controller_unit #(
  parameter int unsigned FULL_POWER       = 1000,
  parameter int unsigned HALF_CYCLE_TICKS = 40000
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // s_tdata: operation [2:0], amount [13:3], zero fill [15:14]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [tpac_pkg::IN_TDATA_W-1:0]      s_tdata,
  // m_tdata: fire_first [0], fire_second [1], mains_lost [2], running [3],
  //          power_level [13:4], delay_first [29:14], delay_second [45:30],
  //          zero fill [47:46]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [tpac_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [tpac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                          cfg_data
);

  logic              dual_heater_mode;
  logic [15:0]       mains_timeout;
  logic              in_vld;
  tpac_pkg::item_t   in_item;
  logic              adv;
  tpac_pkg::result_t res;
  tpac_pkg::result_t res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dual_heater_mode <= tpac_pkg::DUAL_MODE_RST;
      mains_timeout    <= tpac_pkg::MAINS_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tpac_pkg::CFG_DUAL_MODE:     dual_heater_mode <= cfg_data[0];
        tpac_pkg::CFG_MAINS_TIMEOUT: mains_timeout    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // pipeline advance: input register moves when the result register is free
  assign adv      = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.operation <= s_tdata[2:0];
      in_item.amount    <= $signed(s_tdata[13:3]);
    end
  end

  tpac_state #(
    .FULL_POWER       (FULL_POWER),
    .HALF_CYCLE_TICKS (HALF_CYCLE_TICKS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .step    (adv),
    .item    (in_item),
    .dual    (dual_heater_mode),
    .timeout (mains_timeout),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_tdata = {2'b00, res_q.delay_second, res_q.delay_first, res_q.power_level,
                    res_q.running, res_q.mains_lost, res_q.fire_second, res_q.fire_first};

endmodule
